FILE: rtl/ttrw_pkg.sv
// ----------------------------------------------------------------------------
// ttrw_pkg: shared types and constants of the text terminal ring writer
// Command and character codes, register indexes, controller states and the
// control and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ttrw_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned RROW_W = 6;
  localparam int unsigned RCOL_W = 7;
  localparam int unsigned CWR_W  = 6;
  localparam int unsigned CCOL_W = 7;
  localparam int unsigned WST_W  = 6;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CHAR = 3'd0,
    CMD_SCROLL_UP = 3'd1,
    CMD_SCROLL_DOWN = 3'd2,
    CMD_HOME = 3'd3,
    CMD_END = 3'd4,
    CMD_READ_CELL = 3'd5
  } ttrw_cmd_e;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_STRIDE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MODE  = 3'd4;

  localparam logic [7:0] LINE_WIDTH_RST  = 8'd80;
  localparam logic [6:0] WINDOW_ROWS_RST = 7'd25;
  localparam logic [6:0] RING_ROWS_RST   = 7'd64;
  localparam logic [6:0] TAB_STRIDE_RST  = 7'd4;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_NORM, ST_DISP, ST_FILL, ST_BSW, ST_SCAN_RD,
    ST_SCAN_CHK, ST_SCAN_END, ST_WRAP, ST_RECYC, ST_COMMIT, ST_READ_WAIT,
    ST_OUT
  } ttrw_state_e;

  typedef enum logic [2:0] {
    A_XY, A_NXNY, A_X_IDX, A_NX_IDX, A_READ, A_CLR, A_SWEEP
  } ttrw_asel_e;

  typedef enum logic [1:0] {
    WD_ZERO, WD_SPACE, WD_CHAR
  } ttrw_wsel_e;

  typedef struct packed {
    logic       load;
    logic       norm;
    logic       plan;
    logic       end_init;
    logic       idx_inc;
    logic       idx_clr;
    logic       scan_ny;
    logic       scan_col;
    logic       cnt_upd;
    logic       recycle;
    logic       commit;
    logic       scroll_up;
    logic       scroll_dn;
    logic       home;
    logic       read_cap;
    logic       out_load;
    logic       sweep_inc;
    logic       mem_we;
    logic       mem_re;
    ttrw_asel_e asel;
    ttrw_wsel_e wsel;
  } ttrw_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic rs_ge_r;
    logic sweep_last;
    logic bs_noop;
    logic y_zero;
    logic fill_more;
    logic scan_end;
    logic rd_zero;
    logic nx_ge_r;
    logic idx_last;
    logic read_ok;
  } ttrw_sts_t;

endpackage

FILE: rtl/ttrw_in_if.sv
// ----------------------------------------------------------------------------
// ttrw_in_if: command channel
// Valid/ready channel carrying one terminal command.
// ----------------------------------------------------------------------------
interface ttrw_in_if import ttrw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_col;

  modport source (output valid, command, char_code, read_row, read_col, input ready);
  modport sink (input valid, command, char_code, read_row, read_col, output ready);
endinterface

FILE: rtl/ttrw_out_if.sv
// ----------------------------------------------------------------------------
// ttrw_out_if: result channel
// Valid/ready channel carrying one terminal status result.
// ----------------------------------------------------------------------------
interface ttrw_out_if import ttrw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CWR_W-1:0]  cursor_window_row;
  logic [CCOL_W-1:0] cursor_column;
  logic [WST_W-1:0]  window_start;
  logic              scroll_moved;
  logic [CHAR_W-1:0] cell_value;
  logic [CNT_W-1:0]  typed_length;

  modport source (output valid, cursor_window_row, cursor_column, window_start,
                  scroll_moved, cell_value, typed_length, input ready);
  modport sink (input valid, cursor_window_row, cursor_column, window_start,
                scroll_moved, cell_value, typed_length, output ready);
endinterface

FILE: rtl/ttrw_ram.sv
// ----------------------------------------------------------------------------
// ttrw_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ttrw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/ttrw_datapath.sv
// ----------------------------------------------------------------------------
// ttrw_datapath: terminal state, configuration and text store
// Holds cursor, window, ring and count registers and runs the micro-ops
// that the controller issues against the text store.
// ----------------------------------------------------------------------------
module ttrw_datapath import ttrw_pkg::*; #(
  parameter int unsigned MAX_COLS      = 128,
  parameter int unsigned MAX_RING_ROWS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ttrw_ctl_t             ctl_i,
  output ttrw_sts_t             sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic [RROW_W-1:0]     read_row_i,
  input  logic [RCOL_W-1:0]     read_col_i,
  output logic [CWR_W-1:0]      cursor_window_row_o,
  output logic [CCOL_W-1:0]     cursor_column_o,
  output logic [WST_W-1:0]      window_start_o,
  output logic                  scroll_moved_o,
  output logic [CHAR_W-1:0]     cell_value_o,
  output logic [CNT_W-1:0]      typed_length_o
);
  localparam int unsigned CLW   = $clog2(MAX_COLS);
  localparam int unsigned RW    = $clog2(MAX_RING_ROWS);
  localparam int unsigned CA    = CLW + 9;
  localparam int unsigned RA    = RW + 8;
  localparam int unsigned DEPTH = MAX_COLS * MAX_RING_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [7:0] lw_q, lw_d;
  logic [6:0] wrows_q, wrows_d, rrows_q, rrows_d, ts_q, ts_d;
  logic       im_q, im_d;

  logic [RW-1:0]  rs_q, rs_d, crow_q, crow_d, wt_q, wt_d;
  logic [RW:0]    nx_q, nx_d;
  logic [CLW-1:0] ccol_q, ccol_d, ny_q, ny_d;
  logic [CLW:0]   idx_q, idx_d, fend_q, fend_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]  sweep_q, sweep_d;

  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [CHAR_W-1:0] ch_q, ch_d, cell_q, cell_d;
  logic [RROW_W-1:0] rrow_q, rrow_d;
  logic [RCOL_W-1:0] rcol_q, rcol_d;
  logic              moved_q, moved_d;

  logic [CWR_W-1:0]  ocwr_q;
  logic [CCOL_W-1:0] occol_q;
  logic [WST_W-1:0]  owst_q;
  logic              omoved_q;
  logic [CHAR_W-1:0] ocell_q;
  logic [CNT_W-1:0]  ocnt_q;

  logic [CA-1:0] w;
  logic [RA-1:0] r, h;
  logic [AW-1:0] addr;
  logic [CHAR_W-1:0] wdata, rdata;
  logic [CNT_W-1:0]  diff;

  // effective geometry
  always_comb begin
    if (lw_q == '0) w = CA'(1);
    else if (CA'(lw_q) > CA'(MAX_COLS)) w = CA'(MAX_COLS);
    else w = CA'(lw_q);
    if (rrows_q < 7'd2) r = RA'(2);
    else if (RA'(rrows_q) > RA'(MAX_RING_ROWS)) r = RA'(MAX_RING_ROWS);
    else r = RA'(rrows_q);
    if (wrows_q == '0) h = RA'(1);
    else if (RA'(wrows_q) > r) h = r;
    else h = RA'(wrows_q);
  end

  // logical row to physical cell address
  always_comb begin
    logic [RA-1:0]  lrow;
    logic [RA-1:0]  p;
    logic [CLW-1:0] c;
    lrow = '0;
    c    = '0;
    case (ctl_i.asel)
      A_XY: begin
        lrow = RA'(crow_q);
        c    = ccol_q;
      end
      A_NXNY: begin
        lrow = RA'(nx_q);
        c    = ny_q;
      end
      A_X_IDX: begin
        lrow = RA'(crow_q);
        c    = idx_q[CLW-1:0];
      end
      A_NX_IDX: begin
        lrow = RA'(nx_q);
        c    = idx_q[CLW-1:0];
      end
      A_READ: begin
        lrow = RA'(wt_q) + RA'(rrow_q);
        c    = CLW'(rcol_q);
      end
      default: begin
        c = idx_q[CLW-1:0];
      end
    endcase
    p = RA'(rs_q) + lrow;
    if (p >= r) p = p - r;
    // recycle clears the physical row at the ring start
    if (ctl_i.asel == A_CLR) p = RA'(rs_q);
    addr = AW'(p) * AW'(MAX_COLS) + AW'(c);
    if (ctl_i.asel == A_SWEEP) addr = sweep_q;
  end

  always_comb begin
    case (ctl_i.wsel)
      WD_SPACE: wdata = CH_SPACE;
      WD_CHAR:  wdata = ch_q;
      default:  wdata = CH_NUL;
    endcase
  end

  ttrw_ram #(.WIDTH(CHAR_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.mem_we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (ctl_i.mem_re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_comb begin
    sts_o.cmd        = cmd_q;
    sts_o.ch         = ch_q;
    sts_o.rs_ge_r    = RA'(rs_q) >= r;
    sts_o.sweep_last = sweep_q == AW'(DEPTH - 1);
    sts_o.bs_noop    = (ch_q == CH_BS) &&
                       (((crow_q == '0) && (ccol_q == '0)) || (im_q && (cnt_q == '0)));
    sts_o.y_zero     = ccol_q == '0;
    sts_o.fill_more  = idx_q < fend_q;
    sts_o.scan_end   = CA'(idx_q) >= w;
    sts_o.rd_zero    = rdata == CH_NUL;
    sts_o.nx_ge_r    = RA'(nx_q) >= r;
    sts_o.idx_last   = idx_q == (CLW+1)'(MAX_COLS - 1);
    sts_o.read_ok    = (RA'(rrow_q) < h) && (CA'(rcol_q) < w) &&
                       ((RA'(wt_q) + RA'(rrow_q)) < r);
  end

  always_comb begin
    logic [CA-1:0] t;
    logic [CA-1:0] mn;
    logic [RA-1:0] nxr;
    lw_d = lw_q; wrows_d = wrows_q; rrows_d = rrows_q; ts_d = ts_q; im_d = im_q;
    rs_d = rs_q; crow_d = crow_q; wt_d = wt_q; nx_d = nx_q;
    ccol_d = ccol_q; ny_d = ny_q; idx_d = idx_q; fend_d = fend_q;
    cnt_d = cnt_q; sweep_d = sweep_q;
    cmd_d = cmd_q; ch_d = ch_q; rrow_d = rrow_q; rcol_d = rcol_q;
    cell_d = cell_q; moved_d = moved_q;
    t   = '0;
    mn  = (CA'(idx_q) > w - CA'(1)) ? w - CA'(1) : CA'(idx_q);
    nxr = RA'(nx_q);

    if (ctl_i.load) begin
      cmd_d   = command_i;
      ch_d    = char_code_i;
      rrow_d  = read_row_i;
      rcol_d  = read_col_i;
      cell_d  = '0;
      moved_d = 1'b0;
    end

    // bring state in range; ring start reduces by repeated subtraction
    if (ctl_i.norm) begin
      if (RA'(rs_q) >= r) rs_d = RW'(RA'(rs_q) - r);
      if (RA'(crow_q) > r - RA'(1)) crow_d = RW'(r - RA'(1));
      if (CA'(ccol_q) > w - CA'(1)) ccol_d = CLW'(w - CA'(1));
      if (RA'(wt_q) > r - h) wt_d = RW'(r - h);
    end

    if (ctl_i.plan) begin
      nx_d  = (RW+1)'(crow_q);
      ny_d  = '0;
      idx_d = (CLW+1)'(ccol_q);
      case (ch_q)
        CH_NL: nx_d = (RW+1)'(crow_q) + 1'b1;
        CH_CR: nx_d = (RW+1)'(crow_q);
        CH_TAB: begin
          t = CA'(ccol_q) + CA'(ts_q);
          if (t >= w) begin
            nx_d   = (RW+1)'(crow_q) + 1'b1;
            fend_d = (CLW+1)'(w);
          end else begin
            ny_d   = CLW'(t);
            fend_d = (CLW+1)'(t);
          end
        end
        CH_BS: begin
          if (ccol_q == '0) begin
            nx_d  = (RW+1)'(crow_q) - 1'b1;
            idx_d = '0;
          end else begin
            ny_d = ccol_q - 1'b1;
          end
        end
        default: begin
          t = CA'(ccol_q) + CA'(1);
          if (t >= w) nx_d = (RW+1)'(crow_q) + 1'b1;
          else ny_d = CLW'(t);
        end
      endcase
    end

    if (ctl_i.end_init) begin
      nx_d  = (RW+1)'(crow_q);
      idx_d = '0;
    end
    if (ctl_i.idx_inc) idx_d = idx_q + 1'b1;
    if (ctl_i.idx_clr) idx_d = '0;
    if (ctl_i.scan_ny) ny_d = CLW'(mn);
    if (ctl_i.scan_col) ccol_d = CLW'(mn);

    if (ctl_i.cnt_upd && im_q) begin
      case (ch_q)
        CH_CR:   cnt_d = cnt_q;
        CH_BS:   cnt_d = cnt_q - 1'b1;
        CH_TAB:  cnt_d = cnt_q + CNT_W'(idx_q) - CNT_W'(ccol_q);
        default: cnt_d = cnt_q + 1'b1;
      endcase
    end

    // drop the oldest row: all logical rows move back one
    if (ctl_i.recycle) begin
      rs_d = (RA'(rs_q) + RA'(1) == r) ? '0 : rs_q + 1'b1;
      nx_d = (RW+1)'(r - RA'(1));
      if (wt_q != '0) wt_d = wt_q - 1'b1;
    end

    if (ctl_i.commit) begin
      crow_d = RW'(nx_q);
      ccol_d = ny_q;
      if (nxr < RA'(wt_q)) wt_d = RW'(nx_q);
      else if (nxr >= RA'(wt_q) + h) wt_d = RW'(nxr - h + RA'(1));
    end

    if (ctl_i.scroll_up && (wt_q != '0)) begin
      wt_d    = wt_q - 1'b1;
      moved_d = 1'b1;
    end
    if (ctl_i.scroll_dn && (RA'(wt_q) < r - h)) begin
      wt_d    = wt_q + 1'b1;
      moved_d = 1'b1;
    end
    if (ctl_i.home) ccol_d = '0;
    if (ctl_i.read_cap) cell_d = rdata;
    if (ctl_i.sweep_inc) sweep_d = sweep_q + 1'b1;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_WIDTH:  lw_d = cfg_data_i;
        CFG_WINDOW_ROWS: wrows_d = cfg_data_i[6:0];
        CFG_RING_ROWS:   rrows_d = cfg_data_i[6:0];
        CFG_TAB_STRIDE:  ts_d = cfg_data_i[6:0];
        CFG_INPUT_MODE: begin
          if (im_q && !cfg_data_i[0]) cnt_d = '0;
          im_d = cfg_data_i[0];
        end
        default: ;
      endcase
    end
  end

  assign diff = CNT_W'(crow_q) - CNT_W'(wt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q    <= LINE_WIDTH_RST;
      wrows_q <= WINDOW_ROWS_RST;
      rrows_q <= RING_ROWS_RST;
      ts_q    <= TAB_STRIDE_RST;
      im_q    <= 1'b0;
      rs_q    <= '0;
      crow_q  <= '0;
      ccol_q  <= '0;
      wt_q    <= '0;
      cnt_q   <= '0;
      sweep_q <= '0;
    end else begin
      lw_q    <= lw_d;
      wrows_q <= wrows_d;
      rrows_q <= rrows_d;
      ts_q    <= ts_d;
      im_q    <= im_d;
      rs_q    <= rs_d;
      crow_q  <= crow_d;
      ccol_q  <= ccol_d;
      wt_q    <= wt_d;
      cnt_q   <= cnt_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q    <= nx_d;
    ny_q    <= ny_d;
    idx_q   <= idx_d;
    fend_q  <= fend_d;
    cmd_q   <= cmd_d;
    ch_q    <= ch_d;
    rrow_q  <= rrow_d;
    rcol_q  <= rcol_d;
    cell_q  <= cell_d;
    moved_q <= moved_d;
    if (ctl_i.out_load) begin
      ocwr_q   <= diff[CWR_W-1:0];
      occol_q  <= CCOL_W'(ccol_q);
      owst_q   <= WST_W'(wt_q);
      omoved_q <= moved_q;
      ocell_q  <= cell_q;
      ocnt_q   <= cnt_q;
    end
  end

  assign cursor_window_row_o = ocwr_q;
  assign cursor_column_o     = occol_q;
  assign window_start_o      = owst_q;
  assign scroll_moved_o      = omoved_q;
  assign cell_value_o        = ocell_q;
  assign typed_length_o      = ocnt_q;
endmodule

FILE: rtl/ttrw_ctrl.sv
// ----------------------------------------------------------------------------
// ttrw_ctrl: command sequencer
// Clears the store after reset, then walks each command through its
// micro-ops and hands the result to the output register.
// ----------------------------------------------------------------------------
module ttrw_ctrl import ttrw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ttrw_ctl_t ctl_o,
  input  ttrw_sts_t sts_i
);
  ttrw_state_e state_q, state_d;
  logic        ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    ctl_o.asel = A_XY;
    ctl_o.wsel = WD_ZERO;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.mem_we    = 1'b1;
        ctl_o.asel      = A_SWEEP;
        ctl_o.sweep_inc = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_NORM;
        end
      end
      ST_NORM: begin
        ctl_o.norm = 1'b1;
        if (!sts_i.rs_ge_r) state_d = ST_DISP;
      end
      ST_DISP: begin
        state_d = ST_OUT;
        case (sts_i.cmd)
          CMD_PUT_CHAR: begin
            if (!sts_i.bs_noop) begin
              ctl_o.plan = 1'b1;
              case (sts_i.ch)
                CH_NL: begin
                  ctl_o.mem_we = 1'b1;
                  state_d      = ST_WRAP;
                end
                CH_CR:  state_d = ST_WRAP;
                CH_TAB: state_d = ST_FILL;
                CH_BS:  state_d = sts_i.y_zero ? ST_SCAN_RD : ST_BSW;
                default: begin
                  ctl_o.mem_we = 1'b1;
                  ctl_o.wsel   = WD_CHAR;
                  state_d      = ST_WRAP;
                end
              endcase
            end
          end
          CMD_SCROLL_UP:   ctl_o.scroll_up = 1'b1;
          CMD_SCROLL_DOWN: ctl_o.scroll_dn = 1'b1;
          CMD_HOME:        ctl_o.home = 1'b1;
          CMD_END: begin
            ctl_o.end_init = 1'b1;
            state_d        = ST_SCAN_RD;
          end
          CMD_READ_CELL: begin
            if (sts_i.read_ok) begin
              ctl_o.mem_re = 1'b1;
              ctl_o.asel   = A_READ;
              state_d      = ST_READ_WAIT;
            end
          end
          default: ;
        endcase
      end
      ST_FILL: begin
        if (sts_i.fill_more) begin
          ctl_o.mem_we  = 1'b1;
          ctl_o.asel    = A_X_IDX;
          ctl_o.wsel    = WD_SPACE;
          ctl_o.idx_inc = 1'b1;
        end else begin
          state_d = ST_WRAP;
        end
      end
      ST_SCAN_RD: begin
        if (sts_i.scan_end) begin
          state_d = ST_SCAN_END;
        end else begin
          ctl_o.mem_re = 1'b1;
          ctl_o.asel   = A_NX_IDX;
          state_d      = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts_i.rd_zero) begin
          state_d = ST_SCAN_END;
        end else begin
          ctl_o.idx_inc = 1'b1;
          state_d       = ST_SCAN_RD;
        end
      end
      ST_SCAN_END: begin
        if (sts_i.cmd == CMD_END) begin
          ctl_o.scan_col = 1'b1;
          state_d        = ST_OUT;
        end else begin
          ctl_o.scan_ny = 1'b1;
          state_d       = ST_BSW;
        end
      end
      ST_BSW: begin
        ctl_o.mem_we = 1'b1;
        ctl_o.asel   = A_NXNY;
        state_d      = ST_WRAP;
      end
      ST_WRAP: begin
        ctl_o.cnt_upd = 1'b1;
        ctl_o.idx_clr = 1'b1;
        state_d       = sts_i.nx_ge_r ? ST_RECYC : ST_COMMIT;
      end
      ST_RECYC: begin
        ctl_o.mem_we  = 1'b1;
        ctl_o.asel    = A_CLR;
        ctl_o.idx_inc = 1'b1;
        if (sts_i.idx_last) begin
          ctl_o.recycle = 1'b1;
          state_d       = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d      = ST_OUT;
      end
      ST_READ_WAIT: begin
        ctl_o.read_cap = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!ovalid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ovalid_q;
endmodule

FILE: rtl/text_terminal_ring_writer.sv
// ----------------------------------------------------------------------------
// text_terminal_ring_writer: character terminal over a scrollback ring
// Top level joining the command sequencer and the terminal datapath.
// ----------------------------------------------------------------------------
// After reset the block sweeps the text store to NUL, one cell a cycle, and
// takes no command until the sweep is done. Scroll, home, no-op, blocked
// backspace and an out-of-range cell read pass through accept, range fixup,
// dispatch and result; an in-range cell read adds a read wait, and a newline,
// carriage return or printable byte adds the wrap check and commit. A
// backspace within the row adds its cell write before those. A tab writes
// spaces one cell at a time up to the next tab stop before the wrap check.
// Backspace to a previous row and cursor end scan the row one cell at a time
// until a NUL or the line width. Wrapping past the last ring row clears the
// MAX_COLS cells of the recycled row. Shrinking ring_rows repeats the range
// fixup once per ring-start reduction step. A result that waits for the
// receiver holds the sequencer in its result step. All text store accesses
// share one address. A new command is taken while the previous result
// still waits in the output register.
// ----------------------------------------------------------------------------
module text_terminal_ring_writer import ttrw_pkg::*; #(
  parameter int unsigned MAX_COLS      = 128,
  parameter int unsigned MAX_RING_ROWS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ttrw_in_if.sink               in_i,
  ttrw_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  ttrw_ctl_t ctl;
  ttrw_sts_t sts;

  ttrw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  ttrw_datapath #(
    .MAX_COLS      (MAX_COLS),
    .MAX_RING_ROWS (MAX_RING_ROWS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctl_i               (ctl),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .command_i           (in_i.command),
    .char_code_i         (in_i.char_code),
    .read_row_i          (in_i.read_row),
    .read_col_i          (in_i.read_col),
    .cursor_window_row_o (out_o.cursor_window_row),
    .cursor_column_o     (out_o.cursor_column),
    .window_start_o      (out_o.window_start),
    .scroll_moved_o      (out_o.scroll_moved),
    .cell_value_o        (out_o.cell_value),
    .typed_length_o      (out_o.typed_length)
  );
endmodule
